/* rtl/core/trf_pkg.sv */
// ----------------------------------------------------------------------------
// trf_pkg: shared types and constants of the tint ramp and flash unit
// Holds the transfer payload types, the command and mode codes, the
// sequencer states and the request/response types of the shared divider.
// ----------------------------------------------------------------------------
package trf_pkg;

    // Width of one colour channel and of the fixed-point fraction.
    localparam int COLOUR_BITS = 5;
    localparam int FRAC_BITS   = 8;
    localparam int FRAME_BITS  = 8;

    // The divider takes a 5.8 colour difference or a colour times a timer.
    localparam int DIV_NUM_W = COLOUR_BITS + FRAC_BITS;
    localparam int DIV_DEN_W = FRAME_BITS;

    // Number of colour channels.
    localparam int NUM_CH = 3;

    // Command codes.
    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_GRADUAL   = 2'd1,
        OP_IMMEDIATE = 2'd2,
        OP_FLASH     = 2'd3
    } t_op;

    // Colour math modes.
    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_ADD = 2'd1;
    localparam logic [1:0] MODE_SUB = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_STEP_GO,
        ST_STEP_WAIT,
        ST_FLASH_GO,
        ST_FLASH_WAIT,
        ST_DONE
    } t_state;

    // Input item.
    typedef struct packed {
        logic [1:0]             op;
        logic [COLOUR_BITS-1:0] red;
        logic [COLOUR_BITS-1:0] green;
        logic [COLOUR_BITS-1:0] blue;
        logic [1:0]             mode_req;
        logic [FRAME_BITS-1:0]  duration;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [COLOUR_BITS-1:0] out_red;
        logic [COLOUR_BITS-1:0] out_green;
        logic [COLOUR_BITS-1:0] out_blue;
        logic [1:0]             math_mode;
        logic                   ramp_busy;
        logic                   flash_on;
    } t_out_item;

    // Divider request and response.
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* rtl/core/trf_div.sv */
// ----------------------------------------------------------------------------
// trf_div: shared restoring divider
// Produces one quotient bit per cycle. A start loads the operands; done is
// high for one cycle once the quotient is complete.
// ----------------------------------------------------------------------------
module trf_div
    import trf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   w_shift;
    logic [DIV_DEN_W:0]   w_sub;
    logic                 w_ge;

    // One trial subtraction of the shifted remainder.
    always_comb begin
        w_shift = {r_rem, r_quo[DIV_NUM_W-1]};
        w_ge    = (w_shift >= {1'b0, r_den});
        w_sub   = w_shift - {1'b0, r_den};
    end

    // Control: busy flag and bit counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_NUM_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Datapath: partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= w_ge ? w_sub[DIV_DEN_W-1:0] : w_shift[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_busy && (r_cnt == '0);
    assign o_rsp.quotient = r_quo;

endmodule

/* rtl/core/tint_ramp_and_flash_colour_unit.sv */
// ----------------------------------------------------------------------------
// tint_ramp_and_flash_colour_unit: per-frame tint ramp and flash generator
// Drives the fixed colour and colour math mode of a blend stage from frame
// ticks and tint or flash commands.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one command or frame tick per transfer. Each
//   transfer yields exactly one result transfer on the output channel with
//   the fixed colour, the math mode and the ramp and flash status.
//   o_in_stall is high while an item is being worked on; the unit takes one
//   item at a time.
//   A plain command or tick passes through the apply and done states; a
//   ramp phase start adds three step divisions and a running flash adds
//   three scaling divisions, all on the single shared one-bit-per-cycle
//   divider. The sequencer returns to idle after each result before it
//   takes a new item.
//   A finished result waits in the output register while i_out_stall is
//   high; the next item is accepted meanwhile, and its result waits in the
//   sequencer until the output register frees up.
//   Reset (synchronous, active low) clears the tint, the ramp and the flash,
//   sets the flash length to one and leaves the output empty.
// ----------------------------------------------------------------------------
module tint_ramp_and_flash_colour_unit
    import trf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int CB = COLOUR_BITS;
    localparam int AW = COLOUR_BITS + FRAC_BITS;
    localparam int FW = FRAME_BITS;

    // Sequencer.
    t_state r_state, n_state;
    logic [1:0] r_ch;

    // Latched input item.
    t_in_item r_in;

    // Tint and ramp state.
    logic [CB-1:0] r_tint  [NUM_CH];
    logic [AW-1:0] r_accum [NUM_CH];
    logic [AW-1:0] r_step  [NUM_CH];
    logic [CB-1:0] r_pt    [NUM_CH];
    logic [CB-1:0] r_ft    [NUM_CH];
    logic [NUM_CH-1:0] r_step_down;
    logic [1:0]    r_cur;
    logic [1:0]    r_fm;
    logic [FW-1:0] r_fl;
    logic [FW-1:0] r_spf;
    logic [FW-1:0] r_div_frames;

    // Flash state.
    logic [CB-1:0] r_fc [NUM_CH];
    logic [FW-1:0] r_timer;
    logic [FW-1:0] r_flen;
    logic [CB-1:0] r_fq [NUM_CH];

    // Output register.
    logic      r_out_valid;
    t_out_item r_out;

    // Divider interface.
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    // Control from the output decode.
    logic w_accept;
    logic w_out_load;
    logic w_out_take;

    // Apply-stage decode.
    t_op           w_op;
    logic [1:0]    w_m;
    logic [1:0]    w_cm_eff;
    logic          w_two;
    logic [FW-1:0] w_half;
    logic [FW-1:0] w_fl_dec;
    logic          w_start;
    logic [FW-1:0] w_frames;
    logic [FW-1:0] w_flen_req;
    logic [CB-1:0] w_in_col [NUM_CH];
    logic [CB-1:0] w_tgt    [NUM_CH];
    logic [AW-1:0] w_acc_nx [NUM_CH];

    // Per-channel divide operands.
    logic [CB-1:0] w_c;
    logic [CB-1:0] w_t;
    logic          w_down;
    logic [CB-1:0] w_diff;
    logic [AW-1:0] w_prod;

    trf_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    // Decode the latched command and work out whether a ramp phase starts.
    always_comb begin
        w_op        = t_op'(r_in.op);
        w_m         = ((r_in.mode_req == MODE_ADD) || (r_in.mode_req == MODE_SUB))
                      ? r_in.mode_req : MODE_OFF;
        w_cm_eff    = (r_cur == MODE_OFF) ? w_m : r_cur;
        w_two       = (w_m != MODE_OFF) && (w_cm_eff != MODE_OFF) && (w_m != w_cm_eff);
        w_half      = ((r_in.duration >> 1) == '0) ? FW'(1) : (r_in.duration >> 1);
        w_fl_dec    = r_fl - 1'b1;
        w_flen_req  = (r_in.duration == '0) ? FW'(1) : r_in.duration;
        w_in_col[0] = r_in.red;
        w_in_col[1] = r_in.green;
        w_in_col[2] = r_in.blue;
        for (int i = 0; i < NUM_CH; i++) begin
            w_tgt[i]    = (w_m == MODE_OFF) ? '0 : w_in_col[i];
            w_acc_nx[i] = r_step_down[i] ? (r_accum[i] - r_step[i])
                                         : (r_accum[i] + r_step[i]);
        end
        case (w_op)
            OP_TICK: begin
                w_start  = (r_fl != '0) && (w_fl_dec == '0) && (r_spf != '0);
                w_frames = r_spf;
            end
            OP_GRADUAL: begin
                w_start  = (r_in.duration != '0);
                w_frames = w_two ? w_half : r_in.duration;
            end
            default: begin
                w_start  = 1'b0;
                w_frames = r_spf;
            end
        endcase
    end

    // Operands of the division for the channel in hand.
    always_comb begin
        w_c    = r_tint[r_ch];
        w_t    = r_pt[r_ch];
        w_down = (w_t < w_c);
        w_diff = w_down ? (w_c - w_t) : (w_t - w_c);
        w_prod = AW'(r_fc[r_ch]) * AW'(r_timer);
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (w_start) begin
                    n_state = ST_STEP_GO;
                end else if (((w_op == OP_TICK) && (r_timer > FW'(1))) ||
                             (w_op == OP_FLASH) ||
                             ((w_op != OP_TICK) && (r_timer != '0))) begin
                    n_state = ST_FLASH_GO;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_STEP_GO: begin
                n_state = ST_STEP_WAIT;
            end
            ST_STEP_WAIT: begin
                if (w_div_rsp.done) begin
                    if (r_ch != 2'd2) begin
                        n_state = ST_STEP_GO;
                    end else if (r_timer != '0) begin
                        n_state = ST_FLASH_GO;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_FLASH_GO: begin
                n_state = ST_FLASH_WAIT;
            end
            ST_FLASH_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = (r_ch != 2'd2) ? ST_FLASH_GO : ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output decode of the sequencer: handshakes and divider requests.
    always_comb begin
        o_in_stall         = (r_state != ST_IDLE);
        w_accept           = i_in_valid && (r_state == ST_IDLE);
        w_out_take         = r_out_valid && !i_out_stall;
        w_out_load         = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
        w_div_req.start    = (r_state == ST_STEP_GO) || (r_state == ST_FLASH_GO);
        w_div_req.divisor  = (r_state == ST_FLASH_GO) ? r_flen : r_div_frames;
        w_div_req.dividend = (r_state == ST_FLASH_GO) ? w_prod
                                                      : {w_diff, {FRAC_BITS{1'b0}}};
    end

    // Sequencer state and channel counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_APPLY) ||
                (((r_state == ST_STEP_WAIT) || (r_state == ST_FLASH_WAIT)) &&
                 w_div_rsp.done && (r_ch == 2'd2))) begin
                r_ch <= '0;
            end else if (((r_state == ST_STEP_WAIT) || (r_state == ST_FLASH_WAIT)) &&
                         w_div_rsp.done) begin
                r_ch <= r_ch + 1'b1;
            end
        end
    end

    // Input item register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_item;
        end
    end

    // Tint, ramp and flash state: command apply and per-channel step results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_tint[i]  <= '0;
                r_accum[i] <= '0;
                r_step[i]  <= '0;
                r_pt[i]    <= '0;
                r_ft[i]    <= '0;
                r_fc[i]    <= '0;
            end
            r_step_down  <= '0;
            r_cur        <= MODE_OFF;
            r_fm         <= MODE_OFF;
            r_fl         <= '0;
            r_spf        <= '0;
            r_div_frames <= FW'(1);
            r_timer      <= '0;
            r_flen       <= FW'(1);
        end else begin
            if (r_state == ST_APPLY) begin
                if (w_start) begin
                    r_div_frames <= w_frames;
                end
                case (w_op)
                    OP_TICK: begin
                        if (r_fl != '0) begin
                            if (w_fl_dec != '0) begin
                                r_fl <= w_fl_dec;
                                for (int i = 0; i < NUM_CH; i++) begin
                                    r_accum[i] <= w_acc_nx[i];
                                    r_tint[i]  <= w_acc_nx[i][AW-1:FRAC_BITS];
                                end
                            end else begin
                                // Phase end: snap to the target, maybe start phase two.
                                for (int i = 0; i < NUM_CH; i++) begin
                                    r_tint[i] <= r_pt[i];
                                end
                                r_cur <= r_fm;
                                r_fl  <= r_spf;
                                if (r_spf != '0) begin
                                    for (int i = 0; i < NUM_CH; i++) begin
                                        r_pt[i] <= r_ft[i];
                                    end
                                    r_spf <= '0;
                                end
                            end
                        end
                        if (r_timer != '0) begin
                            r_timer <= r_timer - 1'b1;
                        end
                    end
                    OP_GRADUAL: begin
                        for (int i = 0; i < NUM_CH; i++) begin
                            r_ft[i] <= w_tgt[i];
                        end
                        if (r_in.duration == '0) begin
                            for (int i = 0; i < NUM_CH; i++) begin
                                r_tint[i] <= w_tgt[i];
                            end
                            r_cur <= w_m;
                            r_fl  <= '0;
                            r_spf <= '0;
                        end else begin
                            if (r_cur == MODE_OFF) begin
                                r_cur <= w_m;
                                for (int i = 0; i < NUM_CH; i++) begin
                                    r_tint[i] <= '0;
                                end
                            end
                            r_fm <= w_m;
                            r_fl <= w_frames;
                            if (w_two) begin
                                // Mode switch: ramp down to zero first.
                                r_spf <= r_in.duration - w_half;
                                for (int i = 0; i < NUM_CH; i++) begin
                                    r_pt[i] <= '0;
                                end
                            end else begin
                                r_spf <= '0;
                                for (int i = 0; i < NUM_CH; i++) begin
                                    r_pt[i] <= w_tgt[i];
                                end
                            end
                        end
                    end
                    OP_IMMEDIATE: begin
                        for (int i = 0; i < NUM_CH; i++) begin
                            r_tint[i] <= w_in_col[i];
                        end
                        r_cur <= w_m;
                        r_fl  <= '0;
                        r_spf <= '0;
                    end
                    OP_FLASH: begin
                        for (int i = 0; i < NUM_CH; i++) begin
                            r_fc[i] <= w_in_col[i];
                        end
                        r_flen  <= w_flen_req;
                        r_timer <= w_flen_req;
                    end
                    default: begin
                        r_fl <= r_fl;
                    end
                endcase
            end

            // A new phase loads the accumulator and direction of each channel.
            if (r_state == ST_STEP_GO) begin
                r_accum[r_ch]     <= {w_c, {FRAC_BITS{1'b0}}};
                r_step_down[r_ch] <= w_down;
            end

            // Store each finished step quotient.
            if ((r_state == ST_STEP_WAIT) && w_div_rsp.done) begin
                r_step[r_ch] <= w_div_rsp.quotient;
            end
        end
    end

    // Scaled flash colour per channel.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FLASH_WAIT) && w_div_rsp.done) begin
            r_fq[r_ch] <= w_div_rsp.quotient[CB-1:0];
        end
    end

    // Output register: compose the result when the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (r_timer != '0) begin
                r_out.out_red   <= r_fq[0];
                r_out.out_green <= r_fq[1];
                r_out.out_blue  <= r_fq[2];
                r_out.math_mode <= MODE_ADD;
            end else if (r_cur != MODE_OFF) begin
                r_out.out_red   <= r_tint[0];
                r_out.out_green <= r_tint[1];
                r_out.out_blue  <= r_tint[2];
                r_out.math_mode <= r_cur;
            end else begin
                r_out.out_red   <= '0;
                r_out.out_green <= '0;
                r_out.out_blue  <= '0;
                r_out.math_mode <= MODE_OFF;
            end
            r_out.ramp_busy <= (r_fl != '0);
            r_out.flash_on  <= (r_timer != '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
